// ===== src/ptc_pkg.sv =====
// Shared constants, field widths and the controller command type for the peer token cache.
package ptc_pkg;

	localparam int CAPACITY_DEFAULT        = 16;
	localparam int TOKEN_MAX_BYTES_DEFAULT = 256;

	localparam int ADDR_W     = 64;
	localparam int PORT_W     = 16;
	localparam int LEN_W      = 9;
	localparam int TMB_W      = 13;
	localparam int SLOT_OUT_W = 4;
	localparam int MAXE_W     = 5;

	localparam int IN_DATA_W  = 160;
	localparam int OUT_DATA_W = 16;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;

	localparam logic [MAXE_W-1:0] MAX_ENTRIES_RESET = 5'd16;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_KEEP   = 1'b1;

	localparam logic FAMILY_IPV4 = 1'b0;

	typedef struct packed {
		logic load;
		logic cmp;
		logic sel;
		logic wr;
	} ptc_cmd_t;

endpackage

// ===== src/ptc_ctrl.sv =====
// Sequencer for the peer token cache: accept, compare, select, write back.
module ptc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output ptc_pkg::ptc_cmd_t cmd
);
	import ptc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_WR   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_SEL;
			end
			ST_SEL: begin
				cmd.sel = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				// The update and the result go out together, so wait for room in the output.
				if (out_free) begin
					cmd.wr  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.wr) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== src/ptc_dp.sv =====
// Datapath of the peer token cache: key store, recency ranks, match and victim logic, result beat.
module ptc_dp #(
	parameter int CAPACITY        = ptc_pkg::CAPACITY_DEFAULT,
	parameter int TOKEN_MAX_BYTES = ptc_pkg::TOKEN_MAX_BYTES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ptc_pkg::ptc_cmd_t                 cmd,
	input  logic [ptc_pkg::IN_DATA_W-1:0]     in_data,
	input  logic                              in_func,
	input  logic [ptc_pkg::MAXE_W-1:0]        max_entries,
	output logic [ptc_pkg::OUT_DATA_W-1:0]    out_data
);
	import ptc_pkg::*;

	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int LIM_W  = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;

	// Request registers, loaded when the beat is accepted.
	logic              func_q;
	logic              fam_q;
	logic [ADDR_W-1:0] hi_q;
	logic [ADDR_W-1:0] lo_q;
	logic [PORT_W-1:0] port_q;
	logic [LEN_W-1:0]  len_q;

	// Entry store.
	logic [ADDR_W-1:0] key_high_q   [CAPACITY];
	logic [ADDR_W-1:0] key_low_q    [CAPACITY];
	logic [PORT_W-1:0] key_port_q   [CAPACITY];
	logic              key_family_q [CAPACITY];
	logic [LEN_W-1:0]  stored_len_q [CAPACITY];
	logic [SLOT_W-1:0] rank_q       [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    count_q;

	// Per-item work registers.
	logic [CAPACITY-1:0] match_q;
	logic [CAPACITY-1:0] victim_q;
	logic [CAPACITY-1:0] target_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                hit_q;
	logic                evict_q;

	logic [OUT_DATA_W-1:0] out_data_q;

	// Input unpacking, key normalization and length clamp.
	logic              in_fam;
	logic [ADDR_W-1:0] in_hi;
	logic [ADDR_W-1:0] in_lo;
	logic [PORT_W-1:0] in_port;
	logic [LEN_W-1:0]  in_len;
	logic [LEN_W-1:0]  in_len_clamped;

	assign in_fam  = in_data[0];
	assign in_hi   = in_data[64:1];
	assign in_lo   = in_data[128:65];
	assign in_port = in_data[144:129];
	assign in_len  = in_data[153:145];

	always_comb begin
		if ({{(TMB_W-LEN_W){1'b0}}, in_len} > TMB_W'(TOKEN_MAX_BYTES)) begin
			in_len_clamped = LEN_W'(TOKEN_MAX_BYTES);
		end else begin
			in_len_clamped = in_len;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			fam_q  <= in_fam;
			// An IPv4 key uses only the low 32 address bits.
			hi_q   <= (in_fam == FAMILY_IPV4) ? '0 : in_hi;
			lo_q   <= (in_fam == FAMILY_IPV4) ? {32'd0, in_lo[31:0]} : in_lo;
			port_q <= in_port;
			len_q  <= in_len_clamped;
		end
	end

	// Effective entry limit.
	logic [LIM_W-1:0] limit;
	logic [LIM_W-1:0] maxe_ext;

	assign maxe_ext = LIM_W'(max_entries);

	always_comb begin
		if (max_entries == '0) begin
			limit = LIM_W'(1);
		end else if (maxe_ext > LIM_W'(CAPACITY)) begin
			limit = LIM_W'(CAPACITY);
		end else begin
			limit = maxe_ext;
		end
	end

	// Compare step: every entry against the key, and the oldest entry by rank.
	// Valid ranks are distinct and run from 0 to count-1, so the oldest holds count-1.
	logic [SLOT_W-1:0] last_rank;

	assign last_rank = SLOT_W'(count_q - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			for (int i = 0; i < CAPACITY; i++) begin
				match_q[i]  <= valid_q[i] && (key_family_q[i] == fam_q) &&
					(key_high_q[i] == hi_q) && (key_low_q[i] == lo_q) &&
					(key_port_q[i] == port_q);
				victim_q[i] <= valid_q[i] && (rank_q[i] == last_rank);
			end
		end
	end

	// Select step: first matching slot on a hit, first free slot on a miss (an evicted entry's slot counts as free).
	logic                sel_hit;
	logic                sel_evict;
	logic [CAPACITY-1:0] sel_valid;
	logic [CAPACITY-1:0] sel_pick;
	logic [CAPACITY-1:0] sel_onehot;
	logic [SLOT_W-1:0]   sel_slot;

	always_comb begin
		sel_hit    = |match_q;
		sel_evict  = (func_q == FUNC_KEEP) && !sel_hit && (LIM_W'(count_q) >= limit);
		sel_valid  = sel_evict ? (valid_q & ~victim_q) : valid_q;
		sel_pick   = sel_hit ? match_q : ~sel_valid;
		sel_onehot = sel_pick & (~sel_pick + CAPACITY'(1));
		sel_slot   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (sel_onehot[i]) begin
				sel_slot = sel_slot | SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sel) begin
			hit_q    <= sel_hit;
			evict_q  <= sel_evict;
			target_q <= sel_onehot;
			slot_q   <= sel_slot;
		end
	end

	// Write-back step.
	logic [SLOT_W-1:0]   old_rank;
	logic [LEN_W-1:0]    old_len;
	logic [CAPACITY-1:0] kept_valid;

	always_comb begin
		old_rank = '0;
		old_len  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (target_q[i]) begin
				old_rank = old_rank | rank_q[i];
				old_len  = old_len | stored_len_q[i];
			end
		end
		kept_valid = evict_q ? (valid_q & ~victim_q) : valid_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && func_q == FUNC_KEEP) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (target_q[i]) begin
					stored_len_q[i] <= len_q;
					if (!hit_q) begin
						key_family_q[i] <= fam_q;
						key_high_q[i]   <= hi_q;
						key_low_q[i]    <= lo_q;
						key_port_q[i]   <= port_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.wr && func_q == FUNC_KEEP) begin
			if (hit_q) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (target_q[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && rank_q[i] < old_rank) begin
						rank_q[i] <= rank_q[i] + SLOT_W'(1);
					end
				end
			end else begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (target_q[i]) begin
						rank_q[i] <= '0;
					end else if (kept_valid[i]) begin
						rank_q[i] <= rank_q[i] + SLOT_W'(1);
					end
				end
				valid_q <= kept_valid | target_q;
				count_q <= evict_q ? count_q : count_q + CNT_W'(1);
			end
		end
	end

	// Result beat: hit, slot, token length, evicted.
	logic                  res_hit;
	logic [SLOT_OUT_W-1:0] res_slot;
	logic [LEN_W-1:0]      res_len;
	logic                  res_evict;

	always_comb begin
		res_hit   = hit_q;
		res_slot  = SLOT_OUT_W'(slot_q);
		res_len   = len_q;
		res_evict = evict_q;
		if (func_q == FUNC_LOOKUP) begin
			res_evict = 1'b0;
			if (hit_q) begin
				res_len = old_len;
			end else begin
				res_slot = '0;
				res_len  = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			out_data_q <= {1'b0, res_evict, res_len, res_slot, res_hit};
		end
	end

	assign out_data = out_data_q;

endmodule

// ===== src/peer_token_cache_lru_top.sv =====
// Top level of the peer token cache: stream ports, register port, controller and datapath.
//
// Fully associative cache of peer tokens keyed by family, 128-bit address and
// port, with least-recently-kept replacement. Each request beat goes through
// the controller states in order: accept, compare the key against every entry
// and find the oldest entry, pick the target slot, then update the store and
// ranks on a keep. The update step waits while the output register still holds
// a result that has not been taken, and writes the result beat into the output
// register as it updates. The next request can be accepted in the cycle after
// the update; a new request is not taken before the previous one is through. A
// lookup never changes the order; a keep refreshes or fills a slot and
// evicts the oldest entry once max_entries is reached. Only the token length is
// held here; token bytes belong in an external memory indexed by the slot.
module peer_token_cache_lru_top #(
	parameter int CAPACITY        = ptc_pkg::CAPACITY_DEFAULT,
	parameter int TOKEN_MAX_BYTES = ptc_pkg::TOKEN_MAX_BYTES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// peer_family[0], peer_addr_high[64:1], peer_addr_low[128:65],
	// peer_port[144:129], new_token_length[153:145], zeros above
	input  logic [ptc_pkg::IN_DATA_W-1:0]     s_tdata,
	// func[0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hit[0], slot[4:1], token_length[13:5], evicted[14], zero above
	output logic [ptc_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ptc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ptc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ptc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import ptc_pkg::*;

	logic [MAXE_W-1:0] max_entries_q;
	logic              reg_sel;
	ptc_cmd_t          cmd;

	// Only one register exists, at byte address zero.
	assign reg_sel = (paddr == '0);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? APB_DATA_W'(max_entries_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_entries_q <= pwdata[MAXE_W-1:0];
		end
	end

	ptc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ptc_dp #(
		.CAPACITY        (CAPACITY),
		.TOKEN_MAX_BYTES (TOKEN_MAX_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_data     (s_tdata),
		.in_func     (s_tuser),
		.max_entries (max_entries_q),
		.out_data    (m_tdata)
	);

endmodule
